### rtl/oets_pkg.sv
// Package for the odd-even transposition sorter.
// Holds the data width, the default capacity and the per-cell control struct.
// No dependencies.
package oets_pkg;

    localparam int DATA_W           = 32;
    localparam int MAX_ELEMENTS_DEF = 32;

    // Control for one cell in one cycle. At most one member is set.
    typedef struct packed {
        logic load;     // take the incoming value
        logic swap_lo;  // lower cell of a pair: keep the smaller of self and right
        logic swap_hi;  // upper cell of a pair: keep the larger of left and self
        logic shift;    // take the right neighbor's value (output drain)
    } t_cell_ctrl;

endpackage

### rtl/odd_even_transposition_sorter.sv
// Top level of the odd-even transposition sorter.
// Instantiates a chain of oets_cell and holds the load/sort/drain sequencer.
// Depends on oets_pkg and oets_cell.
//
// Usage: values arrive on the input channel (i_value, i_final_item, i_valid,
// o_stall), one transfer per cycle while the block is loading. The transfer
// with i_final_item set ends the set. Up to MAX_ELEMENTS values are kept; the
// values of further transfers are dropped, but a marked transfer still ends
// the set. After the marked transfer the block runs one compare-exchange
// phase per stored value, one phase per cycle across the whole cell chain,
// and then presents the values in ascending order on the output channel
// (o_sorted_value, o_final_out, o_valid, i_stall), one per cycle unless the
// receiver stalls, with o_final_out set on the last one. A set goes through
// loading, the sort phases and the drain, in that order. The drain shifts
// the chain left by one cell for each output transfer, so a stall from the
// receiver simply holds the chain and the current result. o_stall stays
// high from the marked transfer until the last result has been taken.
// Reset empties the block and returns it to loading; stored values need no
// clearing.
module odd_even_transposition_sorter #(
    parameter int MAX_ELEMENTS = oets_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic signed [oets_pkg::DATA_W-1:0]   i_value,
    input  logic                                 i_final_item,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    output logic signed [oets_pkg::DATA_W-1:0]   o_sorted_value,
    output logic                                 o_final_out,
    output logic                                 o_valid,
    input  logic                                 i_stall
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int PW = $clog2(MAX_ELEMENTS);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_OUT
    } t_state;

    t_state         r_state;
    logic [CW-1:0]  r_count;
    logic [PW-1:0]  r_phase;

    logic signed [oets_pkg::DATA_W-1:0] w_value [MAX_ELEMENTS];
    oets_pkg::t_cell_ctrl               w_ctrl  [MAX_ELEMENTS];

    logic in_xfer;
    logic out_xfer;
    logic last_phase;

    assign in_xfer    = i_valid && !o_stall;
    assign out_xfer   = o_valid && !i_stall;
    assign last_phase = (CW'(r_phase) == (r_count - CW'(1)));

    // Per-cell control. In a phase, cell i is the lower cell of its pair when
    // its index parity matches the phase parity, otherwise the upper cell.
    always_comb begin
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            w_ctrl[i].load    = (r_state == ST_LOAD) && in_xfer && (r_count == CW'(i));
            w_ctrl[i].swap_lo = (r_state == ST_SORT) && ((i % 2) == int'(r_phase[0]))
                                && (CW'(i + 1) < r_count);
            w_ctrl[i].swap_hi = (r_state == ST_SORT) && ((i % 2) != int'(r_phase[0]))
                                && (i >= 1) && (CW'(i) < r_count);
            w_ctrl[i].shift   = out_xfer;
        end
    end

    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        logic signed [oets_pkg::DATA_W-1:0] w_left;
        logic signed [oets_pkg::DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_value[g];
        end else begin : g_mid_l
            assign w_left = w_value[g-1];
        end

        if (g == MAX_ELEMENTS - 1) begin : g_last
            assign w_right = w_value[g];
        end else begin : g_mid_r
            assign w_right = w_value[g+1];
        end

        oets_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl[g]),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_value[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_phase <= '0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (in_xfer) begin
                        if (r_count < CW'(MAX_ELEMENTS)) begin
                            r_count <= r_count + CW'(1);
                        end
                        if (i_final_item) begin
                            r_state <= ST_SORT;
                            r_phase <= '0;
                        end
                    end
                end
                ST_SORT: begin
                    if (last_phase) begin
                        r_state <= ST_OUT;
                        r_phase <= '0;
                    end else begin
                        r_phase <= r_phase + PW'(1);
                    end
                end
                ST_OUT: begin
                    if (out_xfer) begin
                        r_count <= r_count - CW'(1);
                        if (r_count == CW'(1)) begin
                            r_state <= ST_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign o_stall        = (r_state != ST_LOAD);
    assign o_valid        = (r_state == ST_OUT);
    assign o_sorted_value = w_value[0];
    assign o_final_out    = (r_count == CW'(1));

`ifndef SYNTH
    a_out_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_count != '0))
        else $error("result presented with an empty store");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ELEMENTS))
        else $error("element count above capacity");

    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SORT) |-> (CW'(r_phase) < r_count))
        else $error("sort phase beyond element count");

    a_final_starts_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_final_item) |=> (r_state == ST_SORT))
        else $error("marked transfer did not start the sort");

    a_last_out_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_final_out) |=> (r_state == ST_LOAD && r_count == '0))
        else $error("block not empty after the last result");
`endif

endmodule

### rtl/oets_cell.sv
// One storage cell of the sorter chain: holds one element.
// Compares with a neighbor during sort phases and shifts left during output.
// Depends on oets_pkg.
module oets_cell (
    input  logic                                 i_clk,
    input  oets_pkg::t_cell_ctrl                 i_ctrl,
    input  logic signed [oets_pkg::DATA_W-1:0]   i_value,
    input  logic signed [oets_pkg::DATA_W-1:0]   i_left,
    input  logic signed [oets_pkg::DATA_W-1:0]   i_right,
    output logic signed [oets_pkg::DATA_W-1:0]   o_value
);

    logic signed [oets_pkg::DATA_W-1:0] r_value;
    logic signed [oets_pkg::DATA_W-1:0] n_value;

    // Equal values are left in place, so each compare is strict.
    always_comb begin
        n_value = r_value;
        if (i_ctrl.load) begin
            n_value = i_value;
        end else if (i_ctrl.swap_lo) begin
            if (r_value > i_right) begin
                n_value = i_right;
            end
        end else if (i_ctrl.swap_hi) begin
            if (i_left > r_value) begin
                n_value = i_left;
            end
        end else if (i_ctrl.shift) begin
            n_value = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule
